/* design/pvs_pkg.sv */
// Shared constants, types and store request format for the packed variable store.
// No dependencies; the other design files except pvs_lane refer to this package by scoped names.
package pvs_pkg;

  localparam int NUM_BANKS      = 8;
  localparam int WORDS_PER_BANK = 2000;
  localparam int Z_BANK_CODE    = 25;
  localparam int Z_BANK         = 7;
  localparam int L_BANK_CODE    = 11;
  localparam int L_BANK         = 6;

  localparam int DEPTH   = NUM_BANKS * WORDS_PER_BANK;
  localparam int BANK_W  = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WIDX_W  = (WORDS_PER_BANK > 1) ? $clog2(WORDS_PER_BANK) : 1;
  localparam int LIM_W   = (WIDX_W + 6 > 17) ? WIDX_W + 6 : 17;

  // raw_type div 26 as (raw * 79) >> 11, exact for every 8-bit raw code
  localparam int TYPE_RADIX  = 26;
  localparam int RECIP       = 79;
  localparam int RECIP_SHIFT = 11;
  localparam int MAX_WCODE   = 5;
  localparam int WORD_LOG    = 5;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_BAD_BANK     = 2'd1;
  localparam logic [1:0] ST_BAD_LOCATION = 2'd2;
  localparam logic [1:0] ST_BAD_WIDTH    = 2'd3;

  typedef struct packed {
    logic [1:0]        status;
    logic [BANK_W-1:0] bank;
    logic [WIDX_W-1:0] widx;
    logic [4:0]        offset;
    logic [2:0]        wl;
  } dec_t;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       wdata;
  } mem_req_t;

endpackage

/* design/pvs_decode.sv */
// Access decoder: splits the raw type code, remaps banks and runs the range checks.
// Depends on pvs_pkg.
module pvs_decode (
  input  logic [7:0]    raw_type,
  input  logic [15:0]   location,
  output pvs_pkg::dec_t dec
);

  logic [14:0]              prod;
  logic [3:0]               wcode;
  logic [7:0]               rem8;
  logic [4:0]               code;
  logic [4:0]               bank_a;
  logic [4:0]               bank_b;
  logic [2:0]               wl;
  logic [2:0]               pl;
  logic [pvs_pkg::LIM_W-1:0] limit;
  logic [4:0]               low;

  always_comb begin
    prod   = {7'd0, raw_type} * 15'(pvs_pkg::RECIP);
    wcode  = 4'(prod >> pvs_pkg::RECIP_SHIFT);
    rem8   = raw_type - 8'({4'd0, wcode} * 8'(pvs_pkg::TYPE_RADIX));
    code   = rem8[4:0];
    bank_a = (code == 5'(pvs_pkg::Z_BANK_CODE)) ? 5'(pvs_pkg::Z_BANK) : code;
    bank_b = (bank_a == 5'(pvs_pkg::L_BANK_CODE)) ? 5'(pvs_pkg::L_BANK) : bank_a;

    // element width log2: whole word counts as 32 bits
    case (wcode)
      4'd0:    wl = 3'd5;
      4'd1:    wl = 3'd0;
      4'd2:    wl = 3'd1;
      4'd3:    wl = 3'd2;
      4'd4:    wl = 3'd3;
      4'd5:    wl = 3'd4;
      default: wl = 3'd5;
    endcase
    pl    = 3'(pvs_pkg::WORD_LOG) - wl;
    limit = pvs_pkg::LIM_W'(pvs_pkg::WORDS_PER_BANK) << pl;
    low   = location[4:0] & 5'((6'd1 << pl) - 6'd1);

    dec.bank   = pvs_pkg::BANK_W'(bank_b);
    dec.widx   = pvs_pkg::WIDX_W'(location >> pl);
    dec.offset = low << wl;
    dec.wl     = wl;

    if ({1'b0, bank_b} >= 6'(pvs_pkg::NUM_BANKS)) begin
      dec.status = pvs_pkg::ST_BAD_BANK;
    end else if (wcode > 4'(pvs_pkg::MAX_WCODE)) begin
      dec.status = pvs_pkg::ST_BAD_WIDTH;
    end else if (pvs_pkg::LIM_W'(location) >= limit) begin
      dec.status = pvs_pkg::ST_BAD_LOCATION;
    end else begin
      dec.status = pvs_pkg::ST_OK;
    end
  end

endmodule

/* design/pvs_lane.sv */
// Shared field unit: extracts a packed element from a word and merges a new one into it.
// Does not depend on pvs_pkg; no package items needed here.
module pvs_lane (
  input  logic [31:0] word,
  input  logic [31:0] value,
  input  logic [4:0]  offset,
  input  logic [2:0]  wl,
  output logic [31:0] elem,
  output logic [31:0] merged
);

  logic [5:0]  bits;
  logic [31:0] mask;

  always_comb begin
    bits = 6'd1 << wl;
    if (wl >= 3'd5) begin
      mask = '1;
    end else begin
      mask = (32'd1 << bits) - 32'd1;
    end
    elem   = (word >> offset) & mask;
    merged = (word & ~(mask << offset)) | ((value & mask) << offset);
  end

endmodule

/* design/pvs_store.sv */
// Single-port word store with registered read data.
// Depends on pvs_pkg for depth, address width and the request struct.
module pvs_store (
  input  logic              clk,
  input  pvs_pkg::mem_req_t req,
  output logic [31:0]       rdata
);

  logic [31:0] mem [pvs_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

/* design/packed_variable_store_access_top.sv */
// Packed variable store: banked 32-bit words with whole-word and packed 1..16-bit access.
// The sequencer walks decode, address, read, modify/write and result steps for each word,
// skipping read and modify/write when a check fails, and takes no new word before it is back
// in S_IDLE; a result still held by out_stall holds the next one in S_RESP.
// Reset (rst, synchronous): clear all DEPTH words one a cycle (16000), in_stall high meanwhile.
// Depends on pvs_pkg, pvs_decode, pvs_lane and pvs_store.
module packed_variable_store_access_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic [7:0]         raw_type,
  input  logic [15:0]        location,
  input  logic signed [31:0] write_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] read_data,
  output logic [1:0]         status
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_ADDR  = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_MOD   = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0]                 state;
  logic [pvs_pkg::ADDR_W-1:0] clr_cnt;

  // latched input word
  logic        kind_r;
  logic [7:0]  raw_r;
  logic [15:0] loc_r;
  logic [31:0] wval_r;

  pvs_pkg::dec_t              dec_c;
  pvs_pkg::dec_t              dec_r;
  logic [pvs_pkg::ADDR_W-1:0] addr_r;
  logic [31:0]                res_data;

  pvs_pkg::mem_req_t req;
  logic [31:0]       rdata;
  logic [31:0]       elem;
  logic [31:0]       merged;
  logic              out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  pvs_decode u_decode (
    .raw_type (raw_r),
    .location (loc_r),
    .dec      (dec_c)
  );

  pvs_lane u_lane (
    .word   (rdata),
    .value  (wval_r),
    .offset (dec_r.offset),
    .wl     (dec_r.wl),
    .elem   (elem),
    .merged (merged)
  );

  pvs_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // Store port: clearing sweep, then read and read-modify-write of the decoded word.
  always_comb begin
    req.re    = 1'b0;
    req.we    = 1'b0;
    req.addr  = addr_r;
    req.wdata = merged;
    case (state)
      S_CLEAR: begin
        req.we    = 1'b1;
        req.addr  = clr_cnt;
        req.wdata = '0;
      end
      S_RD: begin
        req.re = 1'b1;
      end
      S_MOD: begin
        req.we = kind_r;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      // raise the result when a new one loads, else drop it once taken
      out_valid <= (state == S_RESP && out_free) ? 1'b1 : (out_valid && out_stall);
      case (state)
        S_CLEAR: begin
          if (clr_cnt == pvs_pkg::ADDR_W'(pvs_pkg::DEPTH - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          state <= S_ADDR;
        end
        S_ADDR: begin
          state <= (dec_r.status == pvs_pkg::ST_OK) ? S_RD : S_RESP;
        end
        S_RD: begin
          state <= S_MOD;
        end
        S_MOD: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      kind_r <= kind;
      raw_r  <= raw_type;
      loc_r  <= location;
      wval_r <= $unsigned(write_value);
    end
    if (state == S_DEC) begin
      dec_r <= dec_c;
    end
    if (state == S_ADDR) begin
      // bank base plus word index within the bank
      addr_r   <= pvs_pkg::ADDR_W'(pvs_pkg::ADDR_W'(dec_r.bank) *
                                   pvs_pkg::ADDR_W'(pvs_pkg::WORDS_PER_BANK)) +
                  pvs_pkg::ADDR_W'(dec_r.widx);
      res_data <= '0;
    end
    if (state == S_MOD) begin
      res_data <= kind_r ? 32'd0 : elem;
    end
    if (state == S_RESP && out_free) begin
      read_data <= $signed(res_data);
      status    <= dec_r.status;
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for packed_variable_store_access_top: directed table, then random words.
// Depends on pvs_pkg for bank parameters and status codes; expects typed or shadow-store results.
module tb;

  // Access kinds and width codes as they appear in the input word
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  localparam int WC_WORD   = 0;
  localparam int WC_BIT    = 1;
  localparam int WC_PAIR   = 2;
  localparam int WC_NIBBLE = 3;
  localparam int WC_BYTE   = 4;
  localparam int WC_HALF   = 5;
  localparam int WC_BAD    = 6;

  // How a table row is checked: typed-in expectation or the store predictor
  localparam bit BY_MODEL = 1'b0;
  localparam bit BY_TABLE = 1'b1;

  localparam int DIR_ROWS     = 25;
  localparam int RANDOM_ITEMS = 1125;
  localparam int PHASE_LEN    = 100;
  localparam int TAIL_CYCLES  = 48;
  // Allow the clearing pass after reset, which writes all DEPTH words, three times over
  localparam int QUIET_LIMIT  = 3 * pvs_pkg::DEPTH + 1000;

  typedef struct packed {
    logic [31:0] rd;
    logic [1:0]  st;
  } access_result_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  raw;
    logic [15:0] loc;
    logic [31:0] val;
    logic        check;
    logic [31:0] exp_rd;
    logic [1:0]  exp_st;
  } access_row_t;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic               kind        = ACC_READ;
  logic [7:0]         raw_type    = '0;
  logic [15:0]        location    = '0;
  logic signed [31:0] write_value = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic signed [31:0] read_data;
  logic [1:0]         status;

  // Shadow copy of the variable store, cleared as the block clears its own
  logic [31:0]    shadow_words [pvs_pkg::DEPTH];
  access_result_t pending_results [$];
  access_row_t    dir_rows [DIR_ROWS];

  int errors       = 0;
  int in_idle_max  = 3;
  int out_idle_max = 3;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  packed_variable_store_access_top u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .raw_type    (raw_type),
    .location    (location),
    .write_value (write_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data),
    .status      (status)
  );

  function automatic logic [7:0] type_code(input int wc, input int bank_code);
    return 8'(wc * pvs_pkg::TYPE_RADIX + bank_code);
  endfunction

  // Elements packed into one 32-bit word at a width code (1 for whole words)
  function automatic int elements_per_word(input int wc);
    return (wc == WC_WORD) ? 1 : (32 >> (wc - 1));
  endfunction

  // Apply one access to the shadow store and return what the block should answer
  function automatic access_result_t predict_access(input logic k, input logic [7:0] raw,
                                                    input logic [15:0] loc, input logic [31:0] val);
    access_result_t res;
    int             bank;
    int             wc;
    int             per_word;
    int             bits;
    int             shift;
    int             addr;
    logic [31:0]    mask;
    logic [31:0]    word;
    bank   = int'(raw) % pvs_pkg::TYPE_RADIX;
    wc     = int'(raw) / pvs_pkg::TYPE_RADIX;
    res.rd = '0;
    res.st = pvs_pkg::ST_OK;
    // Remap the two aliased bank codes, Z first, then L
    if (bank == pvs_pkg::Z_BANK_CODE) bank = pvs_pkg::Z_BANK;
    if (bank == pvs_pkg::L_BANK_CODE) bank = pvs_pkg::L_BANK;
    if (bank >= pvs_pkg::NUM_BANKS) begin
      res.st = pvs_pkg::ST_BAD_BANK;
    end else if (wc > pvs_pkg::MAX_WCODE) begin
      res.st = pvs_pkg::ST_BAD_WIDTH;
    end else begin
      per_word = elements_per_word(wc);
      if (int'(loc) >= pvs_pkg::WORDS_PER_BANK * per_word) begin
        res.st = pvs_pkg::ST_BAD_LOCATION;
      end else begin
        bits  = 32 / per_word;
        mask  = (bits == 32) ? '1 : ((32'd1 << bits) - 32'd1);
        shift = (int'(loc) % per_word) * bits;
        addr  = bank * pvs_pkg::WORDS_PER_BANK + int'(loc) / per_word;
        word  = shadow_words[addr];
        if (k == ACC_WRITE) begin
          shadow_words[addr] = (word & ~(mask << shift)) | ((val & mask) << shift);
        end else begin
          res.rd = (word >> shift) & mask;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  // Present one word on the input channel and hold it until accepted.
  // Entered and left at a falling edge; valid stays high when no gap follows.
  task automatic send_access(input logic k, input logic [7:0] raw, input logic [15:0] loc,
                             input logic [31:0] val, input logic check,
                             input access_result_t typed);
    int             gap;
    access_result_t predicted;
    gap = $urandom_range(0, in_idle_max);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind        = k;
    raw_type    = raw;
    location    = loc;
    write_value = val;
    in_valid    = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Accepted at this edge: update the shadow store in acceptance order
    predicted = predict_access(k, raw, loc, val);
    pending_results.push_back((check == BY_TABLE) ? typed : predicted);
    @(negedge clk);
  endtask

  // Output side: check every accepted result against the oldest expectation
  access_result_t head;
  int             stall_left = 0;

  initial begin
    forever begin
      @(negedge clk);
      // Hold a waiting result for its drawn number of cycles; idle noise otherwise
      if (out_valid === 1'b1 && stall_left != 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (out_valid !== 1'b1 && out_idle_max != 0) begin
        out_stall = 1'($urandom_range(0, 1));
      end else begin
        out_stall = 1'b0;
      end
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", read_data, '0);
        end else begin
          head = pending_results.pop_front();
          if (read_data !== head.rd) report_mismatch("read_data", read_data, head.rd);
          if (status !== head.st) report_mismatch("status", 32'(status), 32'(head.st));
        end
        stall_left = $urandom_range(0, out_idle_max);
      end
    end
  end

  // Watchdog: end the run after too long without any word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    access_result_t typed;
    logic           k;
    logic [7:0]     raw;
    logic [15:0]    loc;
    int             pick;
    int             sel;
    int             bank_code;
    int             wc;
    int             per_word;
    int             limit;

    foreach (shadow_words[i]) shadow_words[i] = '0;

    // Directed table: typed or predicted expectations for reset contents, extremes and error codes
    dir_rows = '{
      // Fresh store reads back zero at both ends
      '{ACC_READ,  type_code(WC_WORD, 0), 16'd0, 32'h0, BY_TABLE, 32'h0, pvs_pkg::ST_OK},
      '{ACC_READ,  type_code(WC_WORD, 7), 16'd1999, 32'h0, BY_TABLE, 32'h0, pvs_pkg::ST_OK},
      // Whole-word extremes
      '{ACC_WRITE, type_code(WC_WORD, 0), 16'd0, 32'h8000_0000, BY_TABLE, 32'h0, pvs_pkg::ST_OK},
      '{ACC_READ,  type_code(WC_WORD, 0), 16'd0, 32'h0, BY_MODEL, 32'h0, pvs_pkg::ST_OK},
      '{ACC_WRITE, type_code(WC_WORD, 7), 16'd1999, 32'h7FFF_FFFF, BY_TABLE, 32'h0,
        pvs_pkg::ST_OK},
      // Z alias reaches the same bank as code 7
      '{ACC_READ,  type_code(WC_WORD, pvs_pkg::Z_BANK_CODE), 16'd1999, 32'h0, BY_MODEL, 32'h0,
        pvs_pkg::ST_OK},
      // L alias writes bank 6
      '{ACC_WRITE, type_code(WC_WORD, pvs_pkg::L_BANK_CODE), 16'd5, 32'hFFFF_FFFF, BY_TABLE,
        32'h0, pvs_pkg::ST_OK},
      '{ACC_READ,  type_code(WC_WORD, 6), 16'd5, 32'h0, BY_MODEL, 32'h0, pvs_pkg::ST_OK},
      // Bad banks, including a blocked write
      '{ACC_READ,  type_code(WC_WORD, 8), 16'd0, 32'h0, BY_TABLE, 32'h0, pvs_pkg::ST_BAD_BANK},
      '{ACC_READ,  type_code(WC_WORD, 24), 16'd0, 32'h0, BY_TABLE, 32'h0, pvs_pkg::ST_BAD_BANK},
      '{ACC_WRITE, type_code(WC_WORD, 12), 16'd0, 32'hDEAD_BEEF, BY_TABLE, 32'h0,
        pvs_pkg::ST_BAD_BANK},
      // Bad locations at the whole-word limit and the top of the field
      '{ACC_READ,  type_code(WC_WORD, 0), 16'd2000, 32'h0, BY_TABLE, 32'h0,
        pvs_pkg::ST_BAD_LOCATION},
      '{ACC_WRITE, type_code(WC_WORD, 0), 16'hFFFF, 32'h1, BY_TABLE, 32'h0,
        pvs_pkg::ST_BAD_LOCATION},
      // Bad width codes; bank is checked before width
      '{ACC_READ,  type_code(WC_BAD, 0), 16'd0, 32'h0, BY_TABLE, 32'h0, pvs_pkg::ST_BAD_WIDTH},
      '{ACC_WRITE, type_code(WC_BAD, pvs_pkg::Z_BANK_CODE), 16'd0, 32'h5, BY_TABLE, 32'h0,
        pvs_pkg::ST_BAD_WIDTH},
      '{ACC_READ,  type_code(WC_BAD, 8), 16'd0, 32'h0, BY_TABLE, 32'h0, pvs_pkg::ST_BAD_BANK},
      '{ACC_READ,  8'hFF, 16'd0, 32'h0, BY_TABLE, 32'h0, pvs_pkg::ST_BAD_BANK},
      // Single bits at the last element and one past it
      '{ACC_WRITE, type_code(WC_BIT, 0), 16'd63999, 32'hFFFF_FFFF, BY_TABLE, 32'h0,
        pvs_pkg::ST_OK},
      '{ACC_READ,  type_code(WC_BIT, 0), 16'd63999, 32'h0, BY_MODEL, 32'h0, pvs_pkg::ST_OK},
      '{ACC_READ,  type_code(WC_BIT, 0), 16'd64000, 32'h0, BY_TABLE, 32'h0,
        pvs_pkg::ST_BAD_LOCATION},
      // Half-words at the limit
      '{ACC_WRITE, type_code(WC_HALF, 1), 16'd3999, 32'h1234_ABCD, BY_TABLE, 32'h0,
        pvs_pkg::ST_OK},
      '{ACC_READ,  type_code(WC_HALF, 1), 16'd3999, 32'h0, BY_MODEL, 32'h0, pvs_pkg::ST_OK},
      '{ACC_READ,  type_code(WC_HALF, 1), 16'd4000, 32'h0, BY_TABLE, 32'h0,
        pvs_pkg::ST_BAD_LOCATION},
      // A nibble into one word, then the whole word back
      '{ACC_WRITE, type_code(WC_NIBBLE, 2), 16'd7, 32'hF5, BY_TABLE, 32'h0, pvs_pkg::ST_OK},
      '{ACC_READ,  type_code(WC_WORD, 2), 16'd0, 32'h0, BY_MODEL, 32'h0, pvs_pkg::ST_OK}
    };

    // Hold reset, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      typed.rd = dir_rows[i].exp_rd;
      typed.st = dir_rows[i].exp_st;
      send_access(dir_rows[i].kind, dir_rows[i].raw, dir_rows[i].loc, dir_rows[i].val,
                  dir_rows[i].check, typed);
    end

    typed = '0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Redraw idling per phase so some stretches run with no gaps at all
      if (n % PHASE_LEN == 0) begin
        in_idle_max  = ($urandom_range(0, 2) == 0) ? 0 : 3;
        out_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 3;
      end
      k    = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        // Well-formed access; mostly to the first few words so reads land on fresh writes
        sel       = $urandom_range(0, 9);
        bank_code = (sel < 8) ? sel : ((sel == 8) ? pvs_pkg::L_BANK_CODE : pvs_pkg::Z_BANK_CODE);
        wc        = $urandom_range(WC_WORD, WC_HALF);
        per_word  = elements_per_word(wc);
        limit     = pvs_pkg::WORDS_PER_BANK * per_word;
        raw       = type_code(wc, bank_code);
        if ($urandom_range(0, 3) != 0) loc = 16'($urandom_range(0, 4 * per_word - 1));
        else                           loc = 16'($urandom_range(0, limit - 1));
      end else begin
        // Noise: any raw code, locations anywhere or on the edge of the bank
        raw = 8'($urandom_range(0, 255));
        wc  = int'(raw) / pvs_pkg::TYPE_RADIX;
        if (wc <= WC_HALF && $urandom_range(0, 1) == 0) begin
          limit = pvs_pkg::WORDS_PER_BANK * elements_per_word(wc);
          loc   = 16'(limit - 1 + $urandom_range(0, 1));
        end else begin
          loc = 16'($urandom_range(0, 65535));
        end
      end
      send_access(k, raw, loc, $urandom, BY_MODEL, typed);
    end

    // Drop valid and drain; the watchdog covers a result that never comes
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch("results still outstanding", 32'(pending_results.size()), '0);
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
